// File: hdl/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Types, widths, operation codes and the position weight table shared by
// the line position centroid block.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int MAX_SENSORS      = 8;
    localparam int SENSOR_COUNT_DEF = 8;

    localparam int LEVEL_W  = 12;
    localparam int FUNC_W   = 2;
    localparam int SCALE_W  = 10;   // scaled level 0..1000
    localparam int PROD_W   = 22;   // (level - min) * 1000
    localparam int WEIGHT_W = 13;   // position * 1000
    localparam int WPROD_W  = 23;   // scaled * weight
    localparam int WSUM_W   = 26;   // weighted sum
    localparam int TOTAL_W  = 13;   // sum of scaled levels
    localparam int OFFSET_W = 13;
    localparam int ERR_W    = 14;
    localparam int POS_W    = 3;
    localparam int CNT_W    = 4;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CAL     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MEASURE = 2'd2;

    localparam logic [LEVEL_W-1:0]  LEVEL_TOP    = 12'd4095;
    localparam logic [SCALE_W-1:0]  SCALE_TOP    = 10'd1000;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 13'd3500;

    // quotient bits per division: scaled level stays below 1000, centroid below 8192
    localparam logic [CNT_W-1:0] SCALE_STEPS    = 4'd10;
    localparam logic [CNT_W-1:0] CENTROID_STEPS = 4'd13;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [LEVEL_W-1:0] level_0;
        logic [LEVEL_W-1:0] level_1;
        logic [LEVEL_W-1:0] level_2;
        logic [LEVEL_W-1:0] level_3;
        logic [LEVEL_W-1:0] level_4;
        logic [LEVEL_W-1:0] level_5;
        logic [LEVEL_W-1:0] level_6;
        logic [LEVEL_W-1:0] level_7;
    } sweep_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] line_error;
        logic                    line_lost;
    } result_t;

    function automatic logic [WEIGHT_W-1:0] pos_weight(input logic [POS_W-1:0] pos);
        logic [WEIGHT_W-1:0] w;
        case (pos)
            3'd0:    w = 13'd0;
            3'd1:    w = 13'd1000;
            3'd2:    w = 13'd2000;
            3'd3:    w = 13'd3000;
            3'd4:    w = 13'd4000;
            3'd5:    w = 13'd5000;
            3'd6:    w = 13'd6000;
            3'd7:    w = 13'd7000;
            default: w = 13'd0;
        endcase
        return w;
    endfunction

endpackage

// File: hdl/line_position_centroid_top.sv
// ----------------------------------------------------------------------------
// line_position_centroid_top
// Calibrated weighted-centroid line sensor with one shared restoring divider.
// ----------------------------------------------------------------------------
// Clear and calibrate beats are absorbed in the cycle they are accepted.
// A measure beat walks the sensors one at a time through the prepare,
// scale, accumulate and add steps. A sensor that reads zero or full scale
// skips the divider; otherwise its level is divided by its span, one
// quotient bit per cycle. The centroid division and the output step follow,
// all divisions sharing the one bit-per-cycle divider. The input is not
// ready while a measure is in flight; a finished result waits in the output
// register without holding off the next sweep, but a later measure waits in
// its output step until that result is taken.
// ----------------------------------------------------------------------------
module line_position_centroid_top #(
    parameter int SENSOR_COUNT = lpc_pkg::SENSOR_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sweep_valid,
    output logic                          sweep_ready,
    input  lpc_pkg::sweep_t               sweep,
    output logic                          result_valid,
    input  logic                          result_ready,
    output lpc_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lpc_pkg::OFFSET_W-1:0]  cfg_data
);
    import lpc_pkg::*;

    localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_SCALE = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_CDIV  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [LEVEL_W-1:0] lvl_in [MAX_SENSORS];
    logic [LEVEL_W-1:0] lvl_reg [SENSOR_COUNT];
    logic [LEVEL_W-1:0] min_reg [SENSOR_COUNT];
    logic [LEVEL_W-1:0] max_reg [SENSOR_COUNT];

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                cent_mode_reg, cent_mode_next;
    logic                zero_reg, zero_next;
    logic                lost_reg, lost_next;
    logic [LEVEL_W-1:0]  d_reg, d_next;
    logic [TOTAL_W-1:0]  div_reg, div_next;
    logic [TOTAL_W-1:0]  acc_reg, acc_next;
    logic [TOTAL_W-1:0]  num_reg, num_next;
    logic [WPROD_W-1:0]  wprod_reg, wprod_next;
    logic [WSUM_W-1:0]   wsum_reg, wsum_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    logic                sweep_acc;
    logic [LEVEL_W-1:0]  sel_lv, sel_lo, sel_hi;
    logic [PROD_W-1:0]   prod;
    logic [TOTAL_W:0]    shifted;
    logic [TOTAL_W+1:0]  diff;
    logic                ge;
    logic [SCALE_W-1:0]  v;

    assign lvl_in[0] = sweep.level_0;
    assign lvl_in[1] = sweep.level_1;
    assign lvl_in[2] = sweep.level_2;
    assign lvl_in[3] = sweep.level_3;
    assign lvl_in[4] = sweep.level_4;
    assign lvl_in[5] = sweep.level_5;
    assign lvl_in[6] = sweep.level_6;
    assign lvl_in[7] = sweep.level_7;

    assign sweep_ready  = (state_reg == S_IDLE);
    assign sweep_acc    = sweep_valid && sweep_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            offset_reg <= cfg_data;
        end
    end

    // calibration span per sensor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                min_reg[i] <= LEVEL_TOP;
                max_reg[i] <= '0;
            end
        end
        else if (sweep_acc && sweep.func == FUNC_CLEAR)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                min_reg[i] <= LEVEL_TOP;
                max_reg[i] <= '0;
            end
        end
        else if (sweep_acc && sweep.func == FUNC_CAL)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                if (lvl_in[i] > max_reg[i])
                begin
                    max_reg[i] <= lvl_in[i];
                end
                if (lvl_in[i] < min_reg[i])
                begin
                    min_reg[i] <= lvl_in[i];
                end
            end
        end
    end

    // captured sweep
    always_ff @(posedge clk)
    begin
        if (sweep_acc)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                lvl_reg[i] <= lvl_in[i];
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        cnt_next          = cnt_reg;
        cent_mode_next    = cent_mode_reg;
        zero_next         = zero_reg;
        lost_next         = lost_reg;
        d_next            = d_reg;
        div_next          = div_reg;
        acc_next          = acc_reg;
        num_next          = num_reg;
        wprod_next        = wprod_reg;
        wsum_next         = wsum_reg;
        total_next        = total_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;

        sel_lv = lvl_reg[idx_reg];
        sel_lo = min_reg[idx_reg];
        sel_hi = max_reg[idx_reg];
        prod   = PROD_W'(d_reg) * PROD_W'(SCALE_TOP);
        v      = num_reg[SCALE_W-1:0];

        // one restoring step: next dividend bit comes off the top of num
        shifted = {acc_reg, num_reg[TOTAL_W-1]};
        diff    = {1'b0, shifted} - {2'b00, div_reg};
        ge      = !diff[TOTAL_W+1];

        case (state_reg)
            S_IDLE:
            begin
                if (sweep_acc && sweep.func == FUNC_MEASURE)
                begin
                    idx_next   = '0;
                    wsum_next  = '0;
                    total_next = '0;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                zero_next  = (sel_hi <= sel_lo) || (sel_lv <= sel_lo);
                d_next     = sel_lv - sel_lo;
                div_next   = TOTAL_W'(sel_hi - sel_lo);
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                if (zero_reg)
                begin
                    num_next   = '0;
                    state_next = S_ACC;
                end
                else if (TOTAL_W'(d_reg) >= div_reg)
                begin
                    num_next   = TOTAL_W'(SCALE_TOP);
                    state_next = S_ACC;
                end
                else
                begin
                    // quotient < 1000, so the top bits are already below the span
                    acc_next       = TOTAL_W'(prod[PROD_W-1:SCALE_W]);
                    num_next       = {prod[SCALE_W-1:0], {(TOTAL_W-SCALE_W){1'b0}}};
                    cnt_next       = SCALE_STEPS;
                    cent_mode_next = 1'b0;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                acc_next = ge ? diff[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
                num_next = {num_reg[TOTAL_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = cent_mode_reg ? S_FIN : S_ACC;
                end
            end
            S_ACC:
            begin
                wprod_next = WPROD_W'(v) * WPROD_W'(pos_weight(POS_W'(idx_reg)));
                total_next = total_reg + TOTAL_W'(v);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                wsum_next = wsum_reg + WSUM_W'(wprod_reg);
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_CDIV;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_PREP;
                end
            end
            S_CDIV:
            begin
                if (total_reg == '0)
                begin
                    lost_next  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    lost_next      = 1'b0;
                    acc_next       = wsum_reg[WSUM_W-1:TOTAL_W];
                    num_next       = wsum_reg[TOTAL_W-1:0];
                    div_next       = total_reg;
                    cnt_next       = CENTROID_STEPS;
                    cent_mode_next = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_FIN:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    if (lost_reg)
                    begin
                        result_next.line_error = '0;
                        result_next.line_lost  = 1'b1;
                    end
                    else
                    begin
                        result_next.line_error =
                            $signed(ERR_W'(num_reg) - ERR_W'(offset_reg));
                        result_next.line_lost  = 1'b0;
                    end
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        cent_mode_reg <= cent_mode_next;
        zero_reg      <= zero_next;
        lost_reg      <= lost_next;
        d_reg         <= d_next;
        div_reg       <= div_next;
        acc_reg       <= acc_next;
        num_reg       <= num_next;
        wprod_reg     <= wprod_next;
        wsum_reg      <= wsum_next;
        total_reg     <= total_next;
        result_reg    <= result_next;
    end

endmodule

// File: tb/line_position_centroid_top_tb.sv
// ----------------------------------------------------------------------------
// line_position_centroid_top_tb
// Checks the calibrated line sensor end to end. A short table of sweeps covers
// reset, clamping, saturation, empty spans and unused codes. Random phases
// follow, each under its own center offset. Every measure result is checked
// against a predictor that keeps its own copy of the calibration, or against the expected value typed into the table.
// ----------------------------------------------------------------------------
module line_position_centroid_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lpc_pkg::*;

    localparam int SENSOR_COUNT = SENSOR_COUNT_DEF;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 160;   // longer than the worst-case measure
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 90;

    typedef struct {
        sweep_t  s;
        bit      typed;
        result_t r;
    } table_row_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                sweep_valid = 1'b0;
    logic                sweep_ready;
    sweep_t              sweep = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    result_t             result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [OFFSET_W-1:0] cfg_data = '0;

    // predictor state
    logic [LEVEL_W-1:0]  cal_min [SENSOR_COUNT];
    logic [LEVEL_W-1:0]  cal_max [SENSOR_COUNT];
    logic [OFFSET_W-1:0] line_offset;

    result_t     pending_results[$];
    table_row_t  sweep_table[$];
    bit          gaps_on = 1'b1;
    int          err_count = 0;
    int          n_measure = 0, n_lost = 0, n_cal = 0, n_clear = 0, n_unused = 0;
    int          n_offsets = 0;

    line_position_centroid_top #(.SENSOR_COUNT(SENSOR_COUNT)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sweep_valid  (sweep_valid),
        .sweep_ready  (sweep_ready),
        .sweep        (sweep),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        result_ready <= !gaps_on || ($urandom_range(99) >= 23);
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic logic [LEVEL_W-1:0] level_at(input sweep_t s, input int i);
        return s[95-12*i -: 12];
    endfunction

    function automatic result_t centroid_of(input sweep_t s);
        int unsigned weighted, total, lvl, v, cen;
        int          diff;
        result_t     r;
        weighted = 0;
        total = 0;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            lvl = level_at(s, i);
            v = 0;
            // below-min clamps to zero, empty span contributes nothing
            if (cal_max[i] > cal_min[i] && lvl > cal_min[i])
            begin
                v = (lvl - cal_min[i]) * SCALE_TOP / (cal_max[i] - cal_min[i]);
                if (v > SCALE_TOP)
                    v = SCALE_TOP;
            end
            weighted += v * i * 1000;
            total += v;
        end
        if (total == 0)
        begin
            r.line_error = '0;
            r.line_lost = 1'b1;
        end
        else
        begin
            cen = weighted / total;
            diff = int'(cen) - int'(line_offset);
            r.line_error = diff[ERR_W-1:0];
            r.line_lost = 1'b0;
        end
        return r;
    endfunction

    function automatic void clear_calibration();
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            cal_min[i] = LEVEL_TOP;
            cal_max[i] = '0;
        end
    endfunction

    // updates the calibration copy; returns 1 with the prediction on a measure
    function automatic bit track_sweep(input sweep_t s, output result_t r);
        logic [LEVEL_W-1:0] lvl;
        r = '0;
        case (s.func)
            FUNC_CLEAR:
            begin
                clear_calibration();
                n_clear++;
            end
            FUNC_CAL:
            begin
                for (int i = 0; i < SENSOR_COUNT; i++)
                begin
                    lvl = level_at(s, i);
                    if (lvl > cal_max[i])
                        cal_max[i] = lvl;
                    if (lvl < cal_min[i])
                        cal_min[i] = lvl;
                end
                n_cal++;
            end
            FUNC_MEASURE:
            begin
                r = centroid_of(s);
                n_measure++;
                if (r.line_lost)
                    n_lost++;
                return 1'b1;
            end
            default:
                n_unused++;
        endcase
        return 1'b0;
    endfunction

    // entered and left at a rising edge; valid stays up across back-to-back beats
    task automatic send_sweep(input sweep_t s, input bit typed, input result_t typed_res);
        result_t predicted;
        if (gaps_on && $urandom_range(99) < 23)
        begin
            sweep_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 40);
        end
        sweep <= s;
        sweep_valid <= 1'b1;
        @(negedge clk);
        while (!sweep_ready)
            @(negedge clk);
        if (track_sweep(s, predicted))
            pending_results.push_back(typed ? typed_res : predicted);
        @(posedge clk);
    endtask

    task automatic write_offset(input logic [OFFSET_W-1:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        line_offset = value;
        n_offsets++;
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        sweep_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void add_row(input sweep_t s, input bit typed,
                                    input int err, input bit lost);
        table_row_t row;
        row.s = s;
        row.typed = typed;
        row.r.line_error = err[ERR_W-1:0];
        row.r.line_lost = lost;
        sweep_table.push_back(row);
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level(input int i, input bit bright);
        int lo, hi;
        if ($urandom_range(99) < 15 || cal_max[i] <= cal_min[i])
            return LEVEL_W'($urandom_range(LEVEL_TOP));
        if (bright)
        begin
            lo = int'(cal_max[i]) - 300;
            hi = LEVEL_TOP;
        end
        else
        begin
            lo = int'(cal_min[i]) - 100;
            hi = int'(cal_min[i]) + 200;
        end
        if (lo < 0)
            lo = 0;
        if (hi > LEVEL_TOP)
            hi = LEVEL_TOP;
        return LEVEL_W'($urandom_range(hi, lo));
    endfunction

    function automatic sweep_t random_cal();
        logic [8*LEVEL_W-1:0] lv;
        int                   pick;
        lv = '0;
        for (int i = 0; i < 8; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                lv[95-12*i -: 12] = LEVEL_W'($urandom_range(1200));
            else if (pick < 90)
                lv[95-12*i -: 12] = LEVEL_W'($urandom_range(LEVEL_TOP, 2800));
            else
                lv[95-12*i -: 12] = LEVEL_W'($urandom_range(LEVEL_TOP));
        end
        return {FUNC_CAL, lv};
    endfunction

    function automatic sweep_t random_measure();
        logic [8*LEVEL_W-1:0] lv;
        int                   center, width, from_center;
        lv = '0;
        center = $urandom_range(7);
        width = $urandom_range(2);
        for (int i = 0; i < 8; i++)
        begin
            from_center = (i > center) ? i - center : center - i;
            if (i < SENSOR_COUNT)
                lv[95-12*i -: 12] = pick_level(i, from_center <= width);
            else
                lv[95-12*i -: 12] = LEVEL_W'($urandom_range(LEVEL_TOP));
        end
        return {FUNC_MEASURE, lv};
    endfunction

    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result error=%0d lost=%0b",
                                          $signed(result.line_error), result.line_lost));
            else
            begin
                want = pending_results.pop_front();
                if (result.line_error !== want.line_error)
                    report_mismatch($sformatf("line_error got %0d want %0d",
                                              $signed(result.line_error),
                                              $signed(want.line_error)));
                if (result.line_lost !== want.line_lost)
                    report_mismatch($sformatf("line_lost got %0b want %0b",
                                              result.line_lost, want.line_lost));
            end
        end
    end

    initial
    begin
        logic [OFFSET_W-1:0] offset_plan [4];
        int                  phase_items, ncal, pick;
        result_t             none;
        offset_plan = '{13'd0, 13'd7000, 13'd8191, 13'd3500};
        none = '0;
        clear_calibration();
        line_offset = OFFSET_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration has empty spans everywhere
        add_row({FUNC_MEASURE, {8{12'd4095}}}, 1, 0, 1);
        add_row({FUNC_UNUSED, {8{12'hAAA}}}, 0, 0, 0);
        add_row({FUNC_CAL, {8{12'd0}}}, 0, 0, 0);
        add_row({FUNC_CAL, {8{12'd4095}}}, 0, 0, 0);
        add_row({FUNC_MEASURE, {8{12'd0}}}, 1, 0, 1);
        add_row({FUNC_MEASURE, {8{12'd4095}}}, 1, 0, 0);
        add_row({FUNC_MEASURE, 12'd4095, {7{12'd0}}}, 1, -3500, 0);
        add_row({FUNC_MEASURE, {7{12'd0}}, 12'd4095}, 1, 3500, 0);
        add_row({FUNC_MEASURE, {3{12'd0}}, 12'd2048, {4{12'd0}}}, 1, -500, 0);
        // scales to zero by truncation
        add_row({FUNC_MEASURE, 12'd1, {7{12'd0}}}, 1, 0, 1);
        add_row({FUNC_MEASURE, {4{12'h555, 12'hAAA}}}, 0, 0, 0);
        add_row({FUNC_MEASURE, 12'd1000, 12'd3000, 12'd17, 12'd4000,
                 12'd2222, 12'd999, 12'd3333, 12'd64}, 0, 0, 0);
        add_row({FUNC_CLEAR, {8{12'd4095}}}, 0, 0, 0);
        add_row({FUNC_MEASURE, {8{12'd2048}}}, 1, 0, 1);
        add_row({FUNC_CAL, {8{12'd2000}}}, 0, 0, 0);
        add_row({FUNC_MEASURE, {8{12'd3000}}}, 1, 0, 1);
        // odd sensors keep an empty span, even ones get spans of 1, 500, 2095, 10
        add_row({FUNC_CAL, 12'd2001, 12'd2000, 12'd2500, 12'd2000,
                 12'd4095, 12'd2000, 12'd2010, 12'd2000}, 0, 0, 0);
        add_row({FUNC_MEASURE, {8{12'd4095}}}, 0, 0, 0);
        add_row({FUNC_MEASURE, {8{12'd1999}}}, 1, 0, 1);
        add_row({FUNC_MEASURE, {4{12'd2001, 12'd4095}}}, 0, 0, 0);
        add_row({FUNC_MEASURE, 12'd2001, 12'd0, 12'd2000, 12'd4095,
                 12'd2000, 12'd4095, 12'd2000, 12'd4095}, 1, -3500, 0);
        add_row({FUNC_MEASURE, 12'd2001, 12'd0, 12'd2250, 12'd0,
                 12'd3000, 12'd0, 12'd2005, 12'd0}, 0, 0, 0);
        add_row({FUNC_UNUSED, {8{12'd0}}}, 0, 0, 0);
        add_row({FUNC_CLEAR, {8{12'd0}}}, 0, 0, 0);

        foreach (sweep_table[k])
            send_sweep(sweep_table[k].s, sweep_table[k].typed, sweep_table[k].r);
        drain_results();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            gaps_on = (phase != 4);
            if (phase < 4)
                write_offset(offset_plan[phase]);
            else
                write_offset(OFFSET_W'($urandom_range(99) < 80 ? $urandom_range(7000)
                                                               : $urandom_range(8191)));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if (phase_items == 0 || $urandom_range(99) < 4)
                begin
                    // fresh calibration run; its clear is now and then skipped to keep stale spans
                    if ($urandom_range(99) < 80)
                    begin
                        send_sweep({FUNC_CLEAR, 96'($urandom) ^ {3{$urandom}}}, 0, none);
                        phase_items++;
                    end
                    ncal = $urandom_range(6, 1);
                    repeat (ncal)
                        send_sweep(random_cal(), 0, none);
                    phase_items += ncal;
                end
                else
                begin
                    pick = $urandom_range(99);
                    if (pick < 5)
                        send_sweep({FUNC_UNUSED, {3{$urandom}}}, 0, none);
                    else
                    begin
                        if (pick < 9)
                            send_sweep(random_cal(), 0, none);
                        else if (pick < 11)
                            send_sweep({FUNC_CLEAR, {3{$urandom}}}, 0, none);
                        else
                            send_sweep(random_measure(), 0, none);
                        phase_items++;
                    end
                end
            end
            drain_results();
        end

        $display("Ran %0d measures (%0d with the line lost), %0d calibrates, %0d clears,",
                 n_measure, n_lost, n_cal, n_clear);
        $display("%0d unused codes and %0d center offsets, results checked one by one.",
                 n_unused, n_offsets);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
